FILE: design/assert_macros.svh
// Assertion macros shared by the escaper RTL.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/jse_pkg.sv
// Shared types, constants and helpers of the JSON string escaper.
// No dependencies; used by every escaper module.
`default_nettype none

package jse_pkg;

  localparam int unsigned CapW              = 11;
  localparam int unsigned PosW              = 10;
  localparam int unsigned ByteW             = 8;
  localparam int unsigned LenW              = 3;
  localparam int unsigned MaxBufferBytesDef = 1024;
  localparam int unsigned CapReset          = 1024;
  localparam int unsigned QueueDepth        = 2;

  // Characters used in escape sequences
  localparam logic [ByteW-1:0] ChQuote     = 8'h22;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChBs        = 8'h08;
  localparam logic [ByteW-1:0] ChFf        = 8'h0C;
  localparam logic [ByteW-1:0] ChLf        = 8'h0A;
  localparam logic [ByteW-1:0] ChCr        = 8'h0D;
  localparam logic [ByteW-1:0] ChTab       = 8'h09;
  localparam logic [ByteW-1:0] ChLetterB   = 8'h62;
  localparam logic [ByteW-1:0] ChLetterF   = 8'h66;
  localparam logic [ByteW-1:0] ChLetterN   = 8'h6E;
  localparam logic [ByteW-1:0] ChLetterR   = 8'h72;
  localparam logic [ByteW-1:0] ChLetterT   = 8'h74;
  localparam logic [ByteW-1:0] ChLetterU   = 8'h75;
  localparam logic [ByteW-1:0] ChZero      = 8'h30;
  localparam logic [ByteW-1:0] CtrlLimit   = 8'h20;
  localparam logic [ByteW-1:0] HexAlphaOff = 8'h57;  // 'a' - 10

  // Sequence classes decided by the front end
  typedef enum logic [1:0] {
    KIND_RAW  = 2'd0,  // one byte as is
    KIND_PAIR = 2'd1,  // backslash + letter, or + quote/backslash
    KIND_UNI  = 2'd2,  // \u00xx
    KIND_DROP = 2'd3   // does not fit, one overflow result
  } seq_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             escape_enable;
    logic             buffer_start;
  } jse_in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [PosW-1:0]  out_position;
    logic             byte_valid;
    logic             overflow;
    logic             last_of_run;
  } jse_out_t;

  // One queued sequence: class, payload byte or letter, start position
  typedef struct packed {
    seq_kind_e        kind;
    logic [ByteW-1:0] data;
    logic [PosW-1:0]  pos;
  } jse_entry_t;

  function automatic logic [LenW-1:0] seq_len(seq_kind_e kind);
    logic [LenW-1:0] len;
    case (kind)
      KIND_PAIR: len = LenW'(2);
      KIND_UNI:  len = LenW'(6);
      default:   len = LenW'(1);
    endcase
    return len;
  endfunction

  function automatic logic [ByteW-1:0] hex_digit(logic [3:0] v);
    logic [ByteW-1:0] v_ext;
    v_ext = {4'b0000, v};
    return (v < 4'd10) ? (ChZero + v_ext) : (HexAlphaOff + v_ext);
  endfunction

endpackage

`default_nettype wire

FILE: design/jse_queue.sv
// Short FIFO of classified sequences between front end and back end.
// Depends on jse_pkg.
`default_nettype none
`include "assert_macros.svh"

module jse_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jse_pkg::jse_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output jse_pkg::jse_entry_t head_o
);
  import jse_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  jse_entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o       = (count_q == CntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `ASSERT_IMPLY(a_no_push_full, clk_i, rst_ni, push_i, !full_o || pop_i, "push into full queue")
  `ASSERT_IMPLY(a_no_pop_empty, clk_i, rst_ni, pop_i, head_valid_o, "pop from empty queue")

endmodule

`default_nettype wire

FILE: design/jse_front.sv
// Front end: takes input transfers, classifies the escape, applies the fit
// rule and keeps fill count, overflow flag and capacity. Depends on jse_pkg.
`default_nettype none
`include "assert_macros.svh"

module jse_front #(
  parameter int unsigned MaxBufferBytes = jse_pkg::MaxBufferBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  jse_pkg::jse_in_t            in_data_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [jse_pkg::CapW-1:0]    cfg_data_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output jse_pkg::jse_entry_t         entry_o
);
  import jse_pkg::*;

  logic [CapW-1:0]  cap_q;
  logic [CapW-1:0]  fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic [CapW-1:0]  cap_eff;
  logic [CapW-1:0]  base_fill;
  logic             base_ovf;
  logic [CapW:0]    sum;
  logic             drop;
  seq_kind_e        kind;
  logic [ByteW-1:0] data;
  logic [LenW-1:0]  len;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i && !q_full_i;

  // Capacity clamp
  always_comb begin
    if (32'(cap_q) > MaxBufferBytes) begin
      cap_eff = CapW'(MaxBufferBytes);
    end else begin
      cap_eff = cap_q;
    end
  end

  // Escape class
  always_comb begin
    kind = KIND_RAW;
    data = in_data_i.text_byte;
    if (in_data_i.escape_enable) begin
      case (in_data_i.text_byte)
        ChQuote, ChBackslash: kind = KIND_PAIR;
        ChBs: begin
          kind = KIND_PAIR;
          data = ChLetterB;
        end
        ChFf: begin
          kind = KIND_PAIR;
          data = ChLetterF;
        end
        ChLf: begin
          kind = KIND_PAIR;
          data = ChLetterN;
        end
        ChCr: begin
          kind = KIND_PAIR;
          data = ChLetterR;
        end
        ChTab: begin
          kind = KIND_PAIR;
          data = ChLetterT;
        end
        default: begin
          if (in_data_i.text_byte < CtrlLimit) begin
            kind = KIND_UNI;
          end
        end
      endcase
    end
    len = seq_len(kind);
  end

  // Fit rule and state update
  always_comb begin
    base_fill = in_data_i.buffer_start ? '0 : fill_q;
    base_ovf  = in_data_i.buffer_start ? 1'b0 : ovf_q;
    sum       = {1'b0, base_fill} + {{(CapW + 1 - LenW){1'b0}}, len};
    drop      = base_ovf || (sum >= {1'b0, cap_eff});

    entry_o.kind = drop ? KIND_DROP : kind;
    entry_o.data = data;
    entry_o.pos  = base_fill[PosW-1:0];

    fill_d = fill_q;
    ovf_d  = ovf_q;
    if (push_o) begin
      fill_d = drop ? base_fill : sum[CapW-1:0];
      ovf_d  = drop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapW'(CapReset);
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
    end
  end

  `ASSERT_NEXT(a_drop_sets_ovf, clk_i, rst_ni, push_o && drop, ovf_q, "drop left flag clear")

endmodule

`default_nettype wire

FILE: design/jse_back.sv
// Back end: expands the head sequence into the output register, one byte
// per cycle while out_stall_i is low. Depends on jse_pkg.
`default_nettype none
`include "assert_macros.svh"

module jse_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  jse_pkg::jse_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jse_pkg::jse_out_t   out_data_o
);
  import jse_pkg::*;

  logic [LenW-1:0]  k_q, k_d;
  logic [LenW-1:0]  len;
  logic             last;
  logic             load;
  logic             out_valid_q;
  jse_out_t         out_q;
  jse_out_t         res;

  assign len         = seq_len(head_i.kind);
  assign last        = (k_q == len - LenW'(1));
  assign load        = !out_valid_q || !out_stall_i;
  assign pop_o       = head_valid_i && load && last;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Byte k of the head sequence
  always_comb begin
    res.out_byte     = head_i.data;
    res.out_position = head_i.pos + PosW'(k_q);
    res.byte_valid   = (head_i.kind != KIND_DROP);
    res.overflow     = (head_i.kind == KIND_DROP);
    res.last_of_run  = last;
    case (head_i.kind)
      KIND_PAIR: begin
        if (k_q == LenW'(0)) res.out_byte = ChBackslash;
      end
      KIND_UNI: begin
        case (k_q)
          LenW'(0): res.out_byte = ChBackslash;
          LenW'(1): res.out_byte = ChLetterU;
          LenW'(2): res.out_byte = ChZero;
          LenW'(3): res.out_byte = ChZero;
          LenW'(4): res.out_byte = hex_digit(head_i.data[7:4]);
          default:  res.out_byte = hex_digit(head_i.data[3:0]);
        endcase
      end
      KIND_DROP: res.out_byte = '0;
      default:   res.out_byte = head_i.data;
    endcase
  end

  // Byte counter within the sequence
  always_comb begin
    k_d = k_q;
    if (head_valid_i && load) begin
      k_d = last ? '0 : k_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q <= k_d;
      if (load) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      out_q <= res;
    end
  end

  `ASSERT_IMPLY(a_k_in_range, clk_i, rst_ni, head_valid_i, k_q < len, "byte index past sequence")
  `ASSERT_IMPLY(a_drop_single, clk_i, rst_ni, out_valid_q && !out_q.last_of_run,
                out_q.byte_valid, "dropped result not last of run")

endmodule

`default_nettype wire

FILE: design/json_string_escaper.sv
// Top level of the JSON string escaper: front end, sequence queue, back end.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+--------------------------
//  in       | input     | in_valid_i/in_stall_o | in_data_i  (jse_in_t)
//  out      | output    | out_valid_o/out_stall_i | out_data_o (jse_out_t)
//  cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (capacity)
//
// The back end emits one result per cycle while not stalled: a plain byte
// gives one result, a two-letter escape two and a \u00xx escape six.
// A byte's sequence is written into the queue on its transfer, and its results
// then pass through the output register. The
// queue holds two sequences, so input keeps flowing while output is stalled
// until it fills. Reset sets capacity to 1024 and clears fill count, overflow
// flag, queue and output register valid.
`default_nettype none

module json_string_escaper #(
  parameter int unsigned MaxBufferBytes = jse_pkg::MaxBufferBytesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  jse_pkg::jse_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output jse_pkg::jse_out_t        out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [jse_pkg::CapW-1:0] cfg_data_i
);
  import jse_pkg::*;

  logic       q_full;
  logic       push;
  jse_entry_t entry;
  logic       pop;
  logic       head_valid;
  jse_entry_t head;

  jse_front #(
    .MaxBufferBytes(MaxBufferBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  jse_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
